// ===== hdl/hcmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hcmm_pkg;

    localparam int OP_W         = 3;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int ROUTE_W      = 2;
    localparam int MAIN_DEPTH   = 65536;

    localparam int DMA_BYTES_DEF  = 160;
    localparam int BOOT_DEPTH_DEF = 256;

    localparam logic [ADDR_W-1:0] BOOT_OFF_REG  = 16'hFF50;
    localparam logic [ADDR_W-1:0] DMA_REG       = 16'hFF46;
    localparam logic [ADDR_W-1:0] IF_REG        = 16'hFF0F;
    localparam logic [ADDR_W-1:0] DIV_REG       = 16'hFF04;
    localparam logic [ADDR_W-1:0] OAM_BASE      = 16'hFE00;
    localparam logic [ADDR_W-1:0] OAM_END       = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ECHO_OFFSET   = 16'h2000;
    localparam logic [ADDR_W-1:0] ECHO_BASE     = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_LAST     = 16'hFDFF;
    localparam logic [ADDR_W-1:0] UNSUP_REG_A   = 16'hFF4C;
    localparam logic [ADDR_W-1:0] UNSUP_REG_B   = 16'hFF4D;
    localparam logic [ADDR_W-1:0] VRAM_BASE     = 16'h8000;
    localparam logic [ADDR_W-1:0] VRAM_END      = 16'hA000;
    localparam logic [ADDR_W-1:0] XRAM_LAST     = 16'hBFFF;
    localparam logic [ADDR_W-1:0] WRAM_BASE     = 16'hC000;
    localparam logic [ADDR_W-1:0] HIGH_BASE     = 16'hFF00;
    localparam logic [ADDR_W-1:0] BOOT_LAST     = 16'h00FF;
    localparam logic [DATA_W-1:0] OPEN_BUS      = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_DIRECT    = 3'd2,
        OP_BOOT_LOAD = 3'd3,
        OP_POLL      = 3'd4
    } op_t;

    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_INSIDE     = 2'd0,
        ROUTE_CART_READ  = 2'd1,
        ROUTE_CART_WRITE = 2'd2
    } route_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DMA
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } mem_wr_t;

endpackage

`default_nettype wire

// ===== hdl/handheld_console_memory_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Memory map of an 8-bit handheld console.
// Request channel (req_valid / req_stall, op, address, write_data) takes one
// item per accepted edge; response channel (rsp_valid / rsp_stall) returns
// exactly one item for each, in order.
// Writes, direct writes, boot loads, polls and unused ops: one item per
// cycle unless stalled; registered response in the cycle after acceptance.
// Reads served from boot ROM or main RAM: the synchronous RAM read is
// registered, then ST_READ loads the response; no request is taken meanwhile.
// Reads forwarded to the cartridge or of the open-bus registers answer at
// the write rate.
// A decoded write to the DMA register is answered at once, then the block
// copies DMA_BYTES bytes through the single RAM port pair and takes no
// request until the copy is done.
// After reset the main RAM is zeroed by a pass over all 65536 addresses, one
// byte a cycle, with req_stall held high. The boot overlay comes up on and
// the interrupt request flag clear.
// A stalled response holds; the next request is taken in the same cycle the
// pending response leaves.
module handheld_console_memory_map
#(
    parameter int DMA_BYTES  = hcmm_pkg::DMA_BYTES_DEF,
    parameter int BOOT_DEPTH = hcmm_pkg::BOOT_DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire logic [hcmm_pkg::OP_W-1:0]    op,
    input  wire logic [hcmm_pkg::ADDR_W-1:0]  address,
    input  wire logic [hcmm_pkg::DATA_W-1:0]  write_data,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output logic      [hcmm_pkg::DATA_W-1:0]  read_data,
    output logic      [hcmm_pkg::ROUTE_W-1:0] route,
    output logic      [hcmm_pkg::ADDR_W-1:0]  cart_address,
    output logic      [hcmm_pkg::DATA_W-1:0]  cart_data,
    output logic                              request_seen
);
    import hcmm_pkg::*;

    localparam int BOOT_AW = $clog2(BOOT_DEPTH);
    localparam int DMA_CW  = $clog2(DMA_BYTES + 1);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [DMA_CW-1:0]   dma_cnt_reg, dma_cnt_next;
    logic [DATA_W-1:0]   dma_page_reg, dma_page_next;
    logic                overlay_reg, overlay_next;
    logic                flag_reg, flag_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                sel_boot_reg, sel_boot_next;

    logic [DATA_W-1:0]   read_data_reg, read_data_next;
    logic [ROUTE_W-1:0]  route_reg, route_next;
    logic [ADDR_W-1:0]   cart_address_reg, cart_address_next;
    logic [DATA_W-1:0]   cart_data_reg, cart_data_next;
    logic                request_seen_reg, request_seen_next;

    logic [DATA_W-1:0]   boot_mem [0:BOOT_DEPTH-1];
    logic [DATA_W-1:0]   boot_rd_reg;
    logic [BOOT_AW-1:0]  boot_idx;
    logic                boot_wr_en;
    logic                boot_rd_en;

    mem_wr_t             main_wr;
    logic                main_rd_en;
    logic [ADDR_W-1:0]   main_rd_addr;
    logic [DATA_W-1:0]   main_rd_data;

    logic                slot_free;
    logic                accept;
    logic                load_out;
    logic                in_cart;
    logic                boot_hit;
    logic                boot_in_range;
    logic                open_bus;
    logic                echo;
    logic                wr_in_range;
    logic [ADDR_W-1:0]   mapped_addr;
    logic                go_read;
    logic                go_dma;
    logic                dma_done;

    logic [DATA_W-1:0]   res_read_data;
    logic [ROUTE_W-1:0]  res_route;
    logic [ADDR_W-1:0]   res_cart_address;
    logic [DATA_W-1:0]   res_cart_data;
    logic                res_seen;

    hcmm_main_ram u_main_ram
    (
        .clk     (clk),
        .wr      (main_wr),
        .rd_en   (main_rd_en),
        .rd_addr (main_rd_addr),
        .rd_data (main_rd_data)
    );

    // address decode
    always_comb
    begin
        in_cart       = (address < VRAM_BASE) || (address >= VRAM_END && address <= XRAM_LAST);
        boot_hit      = overlay_reg && (address <= BOOT_LAST);
        boot_in_range = address < ADDR_W'(BOOT_DEPTH);
        open_bus      = (address == UNSUP_REG_A) || (address == UNSUP_REG_B);
        echo          = (address >= ECHO_BASE) && (address <= ECHO_LAST);
        mapped_addr   = echo ? (address - ECHO_OFFSET) : address;
        wr_in_range   = (address >= VRAM_BASE && address < VRAM_END)
                     || (address >= WRAM_BASE && address < ECHO_BASE)
                     || (address >= OAM_BASE && address < OAM_END)
                     || (address >= HIGH_BASE);
        go_read       = (op == OP_READ)
                     && (boot_hit ? boot_in_range : (!in_cart && !open_bus));
        go_dma        = (op == OP_WRITE) && !(!overlay_reg && in_cart) && (address == DMA_REG);
        boot_idx      = address[BOOT_AW-1:0];
        dma_done      = dma_cnt_reg == DMA_CW'(DMA_BYTES);
        slot_free     = !rsp_valid_reg || !rsp_stall;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && go_read)
                begin
                    state_next = ST_READ;
                end
                else if (accept && go_dma)
                begin
                    state_next = ST_DMA;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_DMA:
            begin
                if (dma_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall        = 1'b1;
        accept           = 1'b0;
        load_out         = 1'b0;
        main_wr          = '0;
        main_rd_en       = 1'b0;
        main_rd_addr     = mapped_addr;
        boot_wr_en       = 1'b0;
        boot_rd_en       = 1'b0;
        clr_addr_next    = clr_addr_reg;
        dma_cnt_next     = dma_cnt_reg;
        dma_page_next    = dma_page_reg;
        overlay_next     = overlay_reg;
        flag_next        = flag_reg;
        sel_boot_next    = sel_boot_reg;
        res_read_data    = '0;
        res_route        = ROUTE_INSIDE;
        res_cart_address = '0;
        res_cart_data    = '0;
        res_seen         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                main_wr.en    = 1'b1;
                main_wr.addr  = clr_addr_reg;
                main_wr.data  = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                req_stall = !slot_free;
                accept    = req_valid && slot_free;
                if (accept)
                begin
                    load_out      = !go_read;
                    sel_boot_next = boot_hit;
                    case (op_t'(op))
                        OP_READ:
                        begin
                            if (boot_hit)
                            begin
                                if (boot_in_range)
                                begin
                                    boot_rd_en = 1'b1;
                                end
                                else
                                begin
                                    res_read_data = OPEN_BUS;
                                end
                            end
                            else if (in_cart)
                            begin
                                res_route        = ROUTE_CART_READ;
                                res_cart_address = address;
                            end
                            else if (open_bus)
                            begin
                                res_read_data = OPEN_BUS;
                            end
                            else
                            begin
                                main_rd_en = 1'b1;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (!overlay_reg && in_cart)
                            begin
                                res_route        = ROUTE_CART_WRITE;
                                res_cart_address = address;
                                res_cart_data    = write_data;
                            end
                            else
                            begin
                                main_wr.en   = wr_in_range;
                                main_wr.addr = address;
                                main_wr.data = (address == DIV_REG) ? '0 : write_data;
                                if (address == BOOT_OFF_REG)
                                begin
                                    overlay_next = 1'b0;
                                end
                                if (address == DMA_REG)
                                begin
                                    dma_page_next = write_data;
                                    dma_cnt_next  = '0;
                                end
                                if (address == IF_REG)
                                begin
                                    flag_next = 1'b1;
                                end
                            end
                        end
                        OP_DIRECT:
                        begin
                            main_wr.en   = 1'b1;
                            main_wr.addr = address;
                            main_wr.data = write_data;
                        end
                        OP_BOOT_LOAD:
                        begin
                            boot_wr_en = boot_in_range;
                        end
                        OP_POLL:
                        begin
                            res_seen  = flag_reg;
                            flag_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load_out      = 1'b1;
                res_read_data = sel_boot_reg ? boot_rd_reg : main_rd_data;
            end
            ST_DMA:
            begin
                // read byte n while byte n-1 is written back
                main_rd_en   = !dma_done;
                main_rd_addr = {dma_page_reg, 8'h00} + ADDR_W'(dma_cnt_reg);
                main_wr.en   = dma_cnt_reg != '0;
                main_wr.addr = OAM_BASE + ADDR_W'(dma_cnt_reg) - ADDR_W'(1);
                main_wr.data = main_rd_data;
                dma_cnt_next = dma_cnt_reg + DMA_CW'(1);
            end
            default:
            begin
            end
        endcase

        rsp_valid_next    = load_out || (rsp_valid_reg && rsp_stall);
        read_data_next    = load_out ? res_read_data : read_data_reg;
        route_next        = load_out ? res_route : route_reg;
        cart_address_next = load_out ? res_cart_address : cart_address_reg;
        cart_data_next    = load_out ? res_cart_data : cart_data_reg;
        request_seen_next = load_out ? res_seen : request_seen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            dma_cnt_reg   <= '0;
            overlay_reg   <= 1'b1;
            flag_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            dma_cnt_reg   <= dma_cnt_next;
            overlay_reg   <= overlay_next;
            flag_reg      <= flag_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dma_page_reg     <= dma_page_next;
        sel_boot_reg     <= sel_boot_next;
        read_data_reg    <= read_data_next;
        route_reg        <= route_next;
        cart_address_reg <= cart_address_next;
        cart_data_reg    <= cart_data_next;
        request_seen_reg <= request_seen_next;
    end

    always_ff @(posedge clk)
    begin
        if (boot_wr_en)
        begin
            boot_mem[boot_idx] <= write_data;
        end
        if (boot_rd_en)
        begin
            boot_rd_reg <= boot_mem[boot_idx];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_data    = read_data_reg;
    assign route        = route_reg;
    assign cart_address = cart_address_reg;
    assign cart_data    = cart_data_reg;
    assign request_seen = request_seen_reg;

endmodule

`default_nettype wire

// ===== hdl/hcmm_main_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcmm_main_ram
(
    input  wire logic                       clk,
    input  wire hcmm_pkg::mem_wr_t          wr,
    input  wire logic                       rd_en,
    input  wire logic [hcmm_pkg::ADDR_W-1:0] rd_addr,
    output logic      [hcmm_pkg::DATA_W-1:0] rd_data
);
    import hcmm_pkg::*;

    logic [DATA_W-1:0] mem [0:MAIN_DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/hcmm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hcmm_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_stall,
    input wire logic [hcmm_pkg::DATA_W-1:0]  read_data,
    input wire logic [hcmm_pkg::ROUTE_W-1:0] route,
    input wire logic [hcmm_pkg::ADDR_W-1:0]  cart_address,
    input wire logic [hcmm_pkg::DATA_W-1:0]  cart_data,
    input wire logic                         request_seen
);
    import hcmm_pkg::*;

    // stalled item stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    a_inside_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && route == ROUTE_INSIDE |-> cart_address == '0 && cart_data == '0)
        else $error("cartridge fields set on internal item");

    a_cart_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && route == ROUTE_CART_READ
        |-> read_data == '0 && cart_data == '0 && !request_seen)
        else $error("stray fields on forwarded read");

    a_seen_inside: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && request_seen |-> route == ROUTE_INSIDE && read_data == '0)
        else $error("poll item malformed");

endmodule

bind handheld_console_memory_map hcmm_checker u_hcmm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .read_data    (read_data),
    .route        (route),
    .cart_address (cart_address),
    .cart_data    (cart_data),
    .request_seen (request_seen)
);

`default_nettype wire
